// ----- design/stop_word_token_filter_core_assert.svh -----
// assertion helpers for the stop word token filter
`ifndef STOP_WORD_TOKEN_FILTER_CORE_ASSERT_SVH
`define STOP_WORD_TOKEN_FILTER_CORE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define SWTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from a trigger to a condition on the following clock edge
`define SWTF_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- design/swtf_pkg.sv -----
// ----------------------------------------------------------------------------
// swtf_pkg
// shared types, codes and character helpers of the stop word token filter
// ----------------------------------------------------------------------------
package swtf_pkg;

  localparam int DefStopWords  = 64;
  localparam int DefMaxWordLen = 16;

  localparam logic [1:0] ModeStop  = 2'd0;
  localparam logic [1:0] ModeQuery = 2'd1;
  localparam logic [1:0] ModeEnd   = 2'd2;

  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharApos  = 8'd39;
  localparam logic [7:0] CharHyph  = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } swtf_state_e;

  // strobes broadcast from the control to every cell
  typedef struct packed {
    logic load_we;
    logic commit;
    logic tok_we;
    logic tok_clear;
  } swtf_cell_cmd_t;

  function automatic logic is_load_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_kept_char(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
           (c >= 8'd48 && c <= 8'd57) || c == CharSpace || c == CharApos ||
           c == CharHyph;
  endfunction

endpackage

// ----- design/swtf_cell.sv -----
// ----------------------------------------------------------------------------
// swtf_cell
// one stop word slot: stored word, running prefix match, match chain stage
// ----------------------------------------------------------------------------
module swtf_cell #(
  parameter int MaxWordLen = swtf_pkg::DefMaxWordLen,
  parameter int SlotW      = 6,
  parameter int CellIdx    = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swtf_pkg::swtf_cell_cmd_t         cmd_i,
  input  logic [SlotW-1:0]                 slot_i,
  input  logic [$clog2(MaxWordLen)-1:0]    load_pos_i,
  input  logic [7:0]                       load_char_i,
  input  logic [$clog2(MaxWordLen+1)-1:0]  load_len_i,
  input  logic [$clog2(MaxWordLen)-1:0]    tok_pos_i,
  input  logic [7:0]                       tok_char_i,
  input  logic [$clog2(MaxWordLen+1)-1:0]  tok_len_i,
  input  logic [MaxWordLen*8-1:0]          tok_chars_i,
  input  logic                             hit_i,
  output logic                             hit_o
);
  import swtf_pkg::*;

  localparam int LenW = $clog2(MaxWordLen + 1);

  logic [7:0]      word_q [MaxWordLen];
  logic [LenW-1:0] len_q;
  logic            valid_q;
  logic            ok_q;
  logic            hit_q;
  logic            sel;
  logic            prefix_eq;
  logic            mine;

  assign sel = (slot_i == SlotW'(CellIdx));

  // whole prefix compare, used when a word is committed mid token
  always_comb begin
    prefix_eq = 1'b1;
    for (int k = 0; k < MaxWordLen; k++) begin
      if (LenW'(k) < tok_len_i && word_q[k] != tok_chars_i[k*8 +: 8]) begin
        prefix_eq = 1'b0;
      end
    end
  end

  assign mine = valid_q && ok_q && (len_q == tok_len_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && sel) begin
      word_q[load_pos_i] <= load_char_i;
    end
    if (cmd_i.commit && sel) begin
      len_q <= load_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ok_q    <= 1'b1;
      hit_q   <= 1'b0;
    end else begin
      hit_q <= hit_i | mine;
      if (cmd_i.commit && sel) begin
        valid_q <= 1'b1;
        ok_q    <= prefix_eq;
      end else if (cmd_i.tok_clear) begin
        ok_q <= 1'b1;
      end else if (cmd_i.tok_we) begin
        ok_q <= ok_q && (word_q[tok_pos_i] == tok_char_i);
      end
    end
  end

  assign hit_o = hit_q;

endmodule

// ----- design/stop_word_token_filter_core.sv -----
// ----------------------------------------------------------------------------
// stop_word_token_filter_core
// tokenizer that drops query tokens found in a loaded stop word table
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one word per item: mode_i and in_byte_i.
//   mode 0 loads stop word bytes, whitespace ends a stop word.
//   mode 1 feeds query bytes, lowercased and filtered, space ends a token.
//   mode 2 ends the query and finishes the pending stop word and token.
//   output channel carries one word per kept token character, with
//   token_last_o on the final character and token_truncated_o on cut tokens.
// timing:
//   bytes that do not finish a token are accepted at one per cycle.
//   a finishing byte with a pending token runs the match probe down the
//   cell chain, then the kept token leaves at one character per cycle
//   while the output is not stalled; an overlong token skips the probe.
//   in_stall_o stays high while probing and emitting.
// reset:
//   table, token and output register empty; stop word bytes need no clear.
// stall:
//   a stalled output word holds in the output register, emission pauses.
// ----------------------------------------------------------------------------
`include "stop_word_token_filter_core_assert.svh"

module stop_word_token_filter_core #(
  parameter int STOP_WORDS   = swtf_pkg::DefStopWords,
  parameter int MAX_WORD_LEN = swtf_pkg::DefMaxWordLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       token_last_o,
  output logic       token_truncated_o
);
  import swtf_pkg::*;

  localparam int LenW  = $clog2(MAX_WORD_LEN + 1);
  localparam int PosW  = $clog2(MAX_WORD_LEN);
  localparam int SlotW = (STOP_WORDS > 1) ? $clog2(STOP_WORDS) : 1;
  localparam int CntW  = $clog2(STOP_WORDS + 1);

  swtf_state_e state_q, state_d;

  // stop word loader
  logic [CntW-1:0] stop_count_q, stop_count_d;
  logic [LenW-1:0] load_len_q, load_len_d;
  logic            load_ovl_q, load_ovl_d;

  // current token
  logic [7:0]      tok_q [MAX_WORD_LEN];
  logic [LenW-1:0] tok_len_q, tok_len_d;
  logic            tok_ovl_q, tok_ovl_d;
  logic [MAX_WORD_LEN*8-1:0] tok_flat;

  // probe and emit counters
  logic [CntW-1:0] probe_cnt_q, probe_cnt_d;
  logic [LenW-1:0] emit_idx_q, emit_idx_d;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q;
  logic       out_last_q;
  logic       out_trunc_q;

  logic           accept;
  logic           table_free;
  logic           load_space;
  logic [7:0]     lc;
  logic           kept;
  logic           finish;
  logic           commit_ok;
  logic           probe_done;
  logic           load_out;
  logic           emit_last;
  swtf_cell_cmd_t cmd;
  logic [STOP_WORDS-1:0] hit_chain;

  assign accept     = in_valid_i && !in_stall_o;
  assign table_free = (stop_count_q < CntW'(STOP_WORDS));
  assign load_space = is_load_space(in_byte_i);
  assign lc         = to_lower(in_byte_i);
  assign kept       = is_kept_char(lc);
  assign commit_ok  = (load_len_q != '0) && !load_ovl_q && table_free;
  assign finish     = accept && ((mode_i == ModeEnd) ||
                                 (mode_i == ModeQuery && kept && lc == CharSpace));
  assign probe_done = (probe_cnt_q == CntW'(STOP_WORDS));
  assign load_out   = !out_valid_q || !out_stall_i;
  assign emit_last  = (emit_idx_q + LenW'(1) == tok_len_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (finish && tok_len_q != '0) begin
          state_d = tok_ovl_q ? ST_EMIT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (probe_done) begin
          state_d = hit_chain[STOP_WORDS-1] ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs and cell strobes
  always_comb begin
    in_stall_o    = 1'b1;
    cmd.load_we   = 1'b0;
    cmd.commit    = 1'b0;
    cmd.tok_we    = 1'b0;
    cmd.tok_clear = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          case (mode_i)
            ModeStop: begin
              if (load_space) begin
                cmd.commit = commit_ok;
              end else if (load_len_q < LenW'(MAX_WORD_LEN)) begin
                cmd.load_we = table_free;
              end
            end
            ModeQuery: begin
              cmd.tok_we = kept && lc != CharSpace && tok_len_q < LenW'(MAX_WORD_LEN);
            end
            ModeEnd:  cmd.commit = commit_ok;
            default: ;
          endcase
        end
      end
      ST_PROBE: cmd.tok_clear = probe_done && hit_chain[STOP_WORDS-1];
      ST_EMIT:  cmd.tok_clear = load_out && emit_last;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    stop_count_d = stop_count_q;
    load_len_d   = load_len_q;
    load_ovl_d   = load_ovl_q;
    tok_len_d    = tok_len_q;
    tok_ovl_d    = tok_ovl_q;
    probe_cnt_d  = probe_cnt_q;
    emit_idx_d   = emit_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (cmd.commit) begin
      stop_count_d = stop_count_q + CntW'(1);
    end
    if (accept && (mode_i == ModeEnd || (mode_i == ModeStop && load_space))) begin
      load_len_d = '0;
      load_ovl_d = 1'b0;
    end else if (accept && mode_i == ModeStop) begin
      if (load_len_q < LenW'(MAX_WORD_LEN)) begin
        load_len_d = load_len_q + LenW'(1);
      end else begin
        load_ovl_d = 1'b1;
      end
    end

    if (cmd.tok_we) begin
      tok_len_d = tok_len_q + LenW'(1);
    end else if (accept && mode_i == ModeQuery && kept && lc != CharSpace) begin
      tok_ovl_d = 1'b1;
    end
    if (cmd.tok_clear) begin
      tok_len_d = '0;
      tok_ovl_d = 1'b0;
    end

    if (state_q == ST_IDLE) begin
      probe_cnt_d = '0;
      emit_idx_d  = '0;
    end
    if (state_q == ST_PROBE) begin
      probe_cnt_d = probe_cnt_q + CntW'(1);
    end
    if (state_q == ST_EMIT && load_out) begin
      out_valid_d = 1'b1;
      emit_idx_d  = emit_idx_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stop_count_q <= '0;
      load_len_q   <= '0;
      load_ovl_q   <= 1'b0;
      tok_len_q    <= '0;
      tok_ovl_q    <= 1'b0;
      probe_cnt_q  <= '0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      stop_count_q <= stop_count_d;
      load_len_q   <= load_len_d;
      load_ovl_q   <= load_ovl_d;
      tok_len_q    <= tok_len_d;
      tok_ovl_q    <= tok_ovl_d;
      probe_cnt_q  <= probe_cnt_d;
      emit_idx_q   <= emit_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // token characters and output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd.tok_we) begin
      tok_q[tok_len_q[PosW-1:0]] <= lc;
    end
    if (state_q == ST_EMIT && load_out) begin
      out_char_q  <= tok_q[emit_idx_q[PosW-1:0]];
      out_last_q  <= emit_last;
      out_trunc_q <= tok_ovl_q;
    end
  end

  for (genvar k = 0; k < MAX_WORD_LEN; k++) begin : g_flat
    assign tok_flat[k*8 +: 8] = tok_q[k];
  end

  // chain of stop word cells, match bit ripples one cell per cycle
  for (genvar w = 0; w < STOP_WORDS; w++) begin : g_cell
    logic hit_in;
    if (w == 0) begin : g_head
      assign hit_in = 1'b0;
    end else begin : g_link
      assign hit_in = hit_chain[w-1];
    end
    swtf_cell #(
      .MaxWordLen (MAX_WORD_LEN),
      .SlotW      (SlotW),
      .CellIdx    (w)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .slot_i      (stop_count_q[SlotW-1:0]),
      .load_pos_i  (load_len_q[PosW-1:0]),
      .load_char_i (in_byte_i),
      .load_len_i  (load_len_q),
      .tok_pos_i   (tok_len_q[PosW-1:0]),
      .tok_char_i  (lc),
      .tok_len_i   (tok_len_q),
      .tok_chars_i (tok_flat),
      .hit_i       (hit_in),
      .hit_o       (hit_chain[w])
    );
  end

  assign out_valid_o       = out_valid_q;
  assign out_char_o        = out_char_q;
  assign token_last_o      = out_last_q;
  assign token_truncated_o = out_trunc_q;

  `SWTF_ASSERT(a_probe_bound, state_q != ST_PROBE || probe_cnt_q <= CntW'(STOP_WORDS),
               "probe counter ran past the chain length")
  `SWTF_ASSERT(a_tok_bound, tok_len_q <= LenW'(MAX_WORD_LEN), "token length overflow")
  `SWTF_ASSERT(a_emit_bound, state_q != ST_EMIT || emit_idx_q < tok_len_q,
               "emit index past token end")
  `SWTF_ASSERT_NEXT(a_emit_done, state_q == ST_EMIT && load_out && emit_last,
                    tok_len_q == '0 && out_valid_q && out_last_q,
                    "token not cleared after its last word")

endmodule

// ----- tb/sv/stop_word_token_filter_core_checker.sv -----
// ----------------------------------------------------------------------------
// stop_word_token_filter_core_checker
// predicts kept token characters from accepted input words and compares them
// ----------------------------------------------------------------------------
module stop_word_token_filter_core_checker #(
  parameter int STOP_WORDS   = swtf_pkg::DefStopWords,
  parameter int MAX_WORD_LEN = swtf_pkg::DefMaxWordLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_char_i,
  input  logic       token_last_i,
  input  logic       token_truncated_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         kept_count_o
);
  import swtf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       trunc;
  } kept_char_t;

  logic [7:0] table_chars [STOP_WORDS][MAX_WORD_LEN];
  int         table_len   [STOP_WORDS];
  int         table_count;
  int         load_len;
  bit         load_long;
  logic [7:0] tok_chars [MAX_WORD_LEN];
  int         tok_len;
  bit         tok_long;
  kept_char_t kept_q[$];

  assign pending_o = kept_q.size();

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_kept(logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd48 && c <= 8'd57) ||
           c == CharSpace || c == CharApos || c == CharHyph;
  endfunction

  task automatic commit_word();
    if (load_len > 0 && !load_long && table_count < STOP_WORDS) begin
      table_len[table_count] = load_len;
      table_count++;
    end
    load_len  = 0;
    load_long = 0;
  endtask

  task automatic close_token();
    bit hit;
    bit same;
    hit = 0;
    if (tok_len > 0 && !tok_long) begin
      for (int w = 0; w < table_count; w++) begin
        if (table_len[w] == tok_len) begin
          same = 1;
          for (int k = 0; k < tok_len; k++)
            if (table_chars[w][k] != tok_chars[k]) same = 0;
          if (same) hit = 1;
        end
      end
    end
    if (tok_len > 0 && !hit)
      for (int k = 0; k < tok_len; k++)
        kept_q.insert(kept_q.size(), kept_char_t'{tok_chars[k], k + 1 == tok_len, tok_long});
    tok_len  = 0;
    tok_long = 0;
  endtask

  task automatic predict_word(logic [1:0] m, logic [7:0] b);
    logic [7:0] c;
    case (m)
      ModeStop: begin
        if (is_ws(b)) commit_word();
        else if (load_len < MAX_WORD_LEN) begin
          if (table_count < STOP_WORDS) table_chars[table_count][load_len] = b;
          load_len++;
        end else load_long = 1;
      end
      ModeQuery: begin
        c = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
        if (is_kept(c)) begin
          if (c == CharSpace) close_token();
          else if (tok_len < MAX_WORD_LEN) begin
            tok_chars[tok_len] = c;
            tok_len++;
          end else tok_long = 1;
        end
      end
      ModeEnd: begin
        commit_word();
        close_token();
      end
      default: ;
    endcase
  endtask

  initial begin
    foreach (table_chars[w, k]) table_chars[w][k] = '0;
    foreach (table_len[w]) table_len[w] = 0;
    table_count = 0; load_len = 0; load_long = 0; tok_len = 0; tok_long = 0;
    fail_count_o = 0;
    kept_count_o = 0;
  end

  always @(posedge clk_i) begin
    kept_char_t exp_c;
    if (rst_ni) begin
      // output side first: a result never comes in the same edge as its input
      if (out_valid_i && !out_stall_i) begin
        kept_count_o <= kept_count_o + 1;
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected word char=%h last=%b trunc=%b", $time,
                   out_char_i, token_last_i, token_truncated_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = kept_q.pop_front();
          if (exp_c !== {out_char_i, token_last_i, token_truncated_i}) begin
            $display("%0t: expected char=%h last=%b trunc=%b, got char=%h last=%b trunc=%b",
                     $time, exp_c.ch, exp_c.last, exp_c.trunc,
                     out_char_i, token_last_i, token_truncated_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_word(mode_i, in_byte_i);
    end
  end

  final if (kept_q.size() != 0) $display("%0d expected words left", kept_q.size());
endmodule

// ----- tb/sv/stop_word_token_filter_core_test.sv -----
// ----------------------------------------------------------------------------
// stop_word_token_filter_core_test
// drives stop word loads and queries with random gaps and stalls
// ----------------------------------------------------------------------------
module stop_word_token_filter_core_test;
  import swtf_pkg::*;

  // mode code that the block ignores
  localparam logic [1:0] ModeNone = 2'd3;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_stall_o;
  logic [1:0] mode_i = ModeStop;
  logic [7:0] in_byte_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 0;
  logic [7:0] out_char_o;
  logic       token_last_o;
  logic       token_truncated_o;
  int         fail_count;
  int         pending;
  int         kept_count;
  int         word_count = 0;
  bit         calm = 0;       // no idling on either side
  bit         hold_off = 0;   // receiver holds off for a long stretch
  bit         stim_done = 0;

  always #6 clk_i = ~clk_i;

  stop_word_token_filter_core DUT (.*);

  stop_word_token_filter_core_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .in_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_char_i(out_char_o),
    .token_last_i(token_last_o), .token_truncated_i(token_truncated_o),
    .fail_count_o(fail_count), .pending_o(pending), .kept_count_o(kept_count)
  );

  // receiver: random stalls, plus a constant stall while hold_off is set
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1;
    else out_stall_i <= !calm && ($urandom_range(99) < 8);
  end

  // send one word, with an optional random gap before it
  task automatic send(logic [1:0] m, logic [7:0] b);
    while (!calm && ($urandom_range(99) < 8)) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i     <= m;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    word_count++;
  endtask

  // drop valid and wait for a clock edge
  task automatic idle();
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_str(logic [1:0] m, string s);
    for (int i = 0; i < s.len(); i++) send(m, s[i]);
  endtask

  // random query byte, mostly letters from a tiny alphabet so stop words hit
  function automatic logic [7:0] query_byte();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'(97 + $urandom_range(2));
    if (r < 62) return 8'(65 + $urandom_range(2));
    if (r < 80) return CharSpace;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] stop_byte();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'(97 + $urandom_range(2));
    if (r < 85) return CharSpace;
    if (r < 90) return 8'(9 + $urandom_range(4));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: stop words incl. uppercase, overlong, tab/cr separators
    send_str(ModeStop, "the a-b\tAbc\rxxxxxxxxxxxxxxxxxx  it's ");
    send_str(ModeQuery, "The cat ABC a-b  it's x9");
    send(ModeQuery, 8'd200);
    send(ModeQuery, 8'd33);
    send(ModeQuery, 8'hff);
    send(ModeNone, 8'd0);
    send_str(ModeQuery, " zzzzzzzzzzzzzzzzzzzz");
    send(ModeEnd, 8'd0);
    send_str(ModeStop, "dog");
    send(ModeEnd, 8'd0);
    send_str(ModeQuery, "dog 0123456789abcdef");
    send(ModeEnd, 8'hff);
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 40; i++) send(ModeQuery, query_byte());
    join
    // sender pauses until everything has drained
    idle();
    while (pending != 0) @(posedge clk_i);
    // random part: mostly word-shaped load and query runs
    while (word_count < 215) begin
      case ($urandom_range(9))
        0, 1: repeat ($urandom_range(12, 1)) send(ModeStop, stop_byte());
        2: send(ModeEnd, 8'($urandom_range(255)));
        3: send(2'($urandom_range(3)), 8'($urandom_range(255)));
        default: repeat ($urandom_range(10, 1)) send(ModeQuery, query_byte());
      endcase
    end
    // fill the table past its size with no idling to reach the full-table case
    calm = 1;
    for (int i = 0; i < 62; i++) begin
      send(ModeStop, 8'(97 + (i % 26)));
      send(ModeStop, CharSpace);
    end
    calm = 0;
    repeat (30) send(ModeQuery, query_byte());
    send(ModeEnd, 8'd0);
    idle();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d words, received %0d kept characters", word_count, kept_count);
    $display("covered stop loads, full table, overlong words, symbols and stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ----- stop_word_token_filter_core.f -----
+incdir+design
design/swtf_pkg.sv
design/swtf_cell.sv
design/stop_word_token_filter_core.sv
tb/sv/stop_word_token_filter_core_checker.sv
tb/sv/stop_word_token_filter_core_test.sv
